>>> design/assert_macros.svh
// Assertion macros used by the RGBE scanline decoder top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Check that an expression holds at every clock edge outside reset.
`define RGBE_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Check that the consequent follows when the antecedent holds.
`define RGBE_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define RGBE_ASSERT(lbl, clk, rst, prop, msg)
`define RGBE_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`endif

`endif

>>> design/rgbe_pkg.sv
// Shared constants and types of the RGBE scanline decoder.
package rgbe_pkg;

   // Default size limits
   localparam int unsigned MAX_WIDTH_DEF = 4096;
   localparam int unsigned MAX_ROWS_DEF  = 2048;

   // Register widths
   localparam int unsigned WIDTH_REG_W = 13;
   localparam int unsigned ROWS_REG_W  = 12;

   // Register indexes
   localparam logic CSR_ROW_WIDTH  = 1'b0;
   localparam logic CSR_IMAGE_ROWS = 1'b1;

   // Status codes
   localparam logic [2:0] ST_OK               = 3'd0;
   localparam logic [2:0] ST_WIDTH_MISMATCH   = 3'd1;
   localparam logic [2:0] ST_RUN_OVERFLOW     = 3'd3;
   localparam logic [2:0] ST_ZERO_LITERAL     = 3'd4;
   localparam logic [2:0] ST_LITERAL_OVERFLOW = 3'd5;

   // Channel codes
   localparam logic [1:0] CH_EXP = 2'd3;

   // Coding constants
   localparam logic [7:0] RUN_BIAS       = 8'd128;
   localparam logic [7:0] NEW_STYLE_MARK = 8'd2;

   // Results caused by one byte; a flat head expands to four spans
   typedef struct packed {
      logic       multi;
      logic [2:0] status;
      logic [1:0] channel;
      logic [10:0] row;
      logic [11:0] start_x;
      logic [6:0] len;
      logic [7:0] value;
      logic       is_run;
      logic       row_done;
      logic       image_done;
      logic [7:0] head0;
      logic [7:0] head1;
      logic [7:0] head2;
   } rsp_bundle_type;

endpackage

>>> design/rgbe_rle_scanline_decoder.sv
// Radiance RGBE run-length scanline decoder, top level with result queue.
// The result bundle of an accepted byte is registered into the queue before its first span is offered.
// Throughput: one byte per cycle while the queue tail is free; a flat row head expands into four result spans.
// The decoder state updates in the accept cycle; a two-entry bundle queue buffers results.
// Reset is synchronous and active high: both registers return to 1, head expected.
`include "assert_macros.svh"

module rgbe_rle_scanline_decoder #(
   parameter int unsigned MAX_WIDTH = rgbe_pkg::MAX_WIDTH_DEF,
   parameter int unsigned MAX_ROWS  = rgbe_pkg::MAX_ROWS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic                          csr_index,
   input  logic [rgbe_pkg::WIDTH_REG_W-1:0] csr_wr_data,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [7:0]                    req_data_byte,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [2:0]                    rsp_status,
   output logic [1:0]                    rsp_channel,
   output logic [10:0]                   rsp_row_index,
   output logic [11:0]                   rsp_start_x,
   output logic [6:0]                    rsp_span_length,
   output logic [7:0]                    rsp_byte_value,
   output logic                          rsp_is_run,
   output logic                          rsp_row_done,
   output logic                          rsp_image_done,
   output logic                          rsp_last
);

   logic [rgbe_pkg::WIDTH_REG_W-1:0] width_ff;
   logic [rgbe_pkg::ROWS_REG_W-1:0]  rows_ff;

   rgbe_pkg::rsp_bundle_type new_bnd, head_ff, head_in, tail_ff, tail_in;
   logic       head_vld_ff, head_vld_in, tail_vld_ff, tail_vld_in;
   logic [1:0] sub_ff, sub_in;
   logic       accept, push, last_sub, pop, step;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= rgbe_pkg::WIDTH_REG_W'(1);
         rows_ff  <= rgbe_pkg::ROWS_REG_W'(1);
      end else if (csr_wr_en) begin
         unique case (csr_index)
            rgbe_pkg::CSR_ROW_WIDTH:  width_ff <= csr_wr_data;
            rgbe_pkg::CSR_IMAGE_ROWS: rows_ff  <= csr_wr_data[rgbe_pkg::ROWS_REG_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign req_stall = tail_vld_ff;
   assign accept    = req_valid && !req_stall;

   rgbe_dec #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_ROWS  (MAX_ROWS)
   ) u_dec (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .data_byte  (req_data_byte),
      .row_width  (width_ff),
      .image_rows (rows_ff),
      .push       (push),
      .bundle     (new_bnd)
   );

   // Expand the head bundle into result transactions
   assign last_sub = !head_ff.multi || (sub_ff == 2'd3);
   assign pop      = head_vld_ff && !rsp_stall && last_sub;
   assign step     = head_vld_ff && !rsp_stall && !last_sub;

   always_comb begin
      rsp_valid       = head_vld_ff;
      rsp_status      = head_ff.status;
      rsp_channel     = head_ff.channel;
      rsp_row_index   = head_ff.row;
      rsp_start_x     = head_ff.start_x;
      rsp_span_length = head_ff.len;
      rsp_byte_value  = head_ff.value;
      rsp_is_run      = head_ff.is_run;
      rsp_row_done    = head_ff.row_done;
      rsp_image_done  = head_ff.image_done;
      rsp_last        = last_sub;
      if (!last_sub) begin
         // leading flat head pixels come from the stored head bytes
         rsp_channel    = sub_ff;
         rsp_row_done   = 1'b0;
         rsp_image_done = 1'b0;
         unique case (sub_ff)
            2'd0:    rsp_byte_value = head_ff.head0;
            2'd1:    rsp_byte_value = head_ff.head1;
            default: rsp_byte_value = head_ff.head2;
         endcase
      end
   end

   // Advance the bundle queue
   always_comb begin
      head_in     = head_ff;
      head_vld_in = head_vld_ff;
      tail_in     = tail_ff;
      tail_vld_in = tail_vld_ff;
      sub_in      = step ? (sub_ff + 2'd1) : sub_ff;
      if (!head_vld_ff) begin
         head_in     = new_bnd;
         head_vld_in = push;
         sub_in      = 2'd0;
      end else if (pop) begin
         sub_in = 2'd0;
         if (tail_vld_ff) begin
            head_in     = tail_ff;
            tail_in     = new_bnd;
            tail_vld_in = push;
         end else begin
            head_in     = new_bnd;
            head_vld_in = push;
         end
      end else if (push) begin
         tail_in     = new_bnd;
         tail_vld_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_vld_ff <= 1'b0;
         tail_vld_ff <= 1'b0;
         sub_ff      <= 2'd0;
      end else begin
         head_vld_ff <= head_vld_in;
         tail_vld_ff <= tail_vld_in;
         sub_ff      <= sub_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

   `RGBE_ASSERT(a_tail_needs_head, clock, reset, !(tail_vld_ff && !head_vld_ff), "tail entry without head entry")
   `RGBE_ASSERT_IMPL(a_error_ends_byte, clock, reset, rsp_valid && (rsp_status != rgbe_pkg::ST_OK), rsp_last && (rsp_span_length == 7'd0), "error result not last or nonzero length")
   `RGBE_ASSERT_IMPL(a_sub_advances, clock, reset, rsp_valid && !rsp_stall && !rsp_last, ##1 (rsp_valid && (sub_ff == $past(sub_ff) + 2'd1)), "flat head expansion skipped a span")

endmodule

>>> design/rgbe_dec.sv
// Scanline decode state machine: row phase, channel, column and counters.
module rgbe_dec #(
   parameter int unsigned MAX_WIDTH = rgbe_pkg::MAX_WIDTH_DEF,
   parameter int unsigned MAX_ROWS  = rgbe_pkg::MAX_ROWS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [7:0]                    data_byte,
   input  logic [rgbe_pkg::WIDTH_REG_W-1:0] row_width,
   input  logic [rgbe_pkg::ROWS_REG_W-1:0]  image_rows,
   output logic                          push,
   output rgbe_pkg::rsp_bundle_type      bundle
);

   localparam int unsigned RegWMax = (1 << rgbe_pkg::WIDTH_REG_W) - 1;
   localparam int unsigned RegRMax = (1 << rgbe_pkg::ROWS_REG_W) - 1;
   localparam int unsigned EffWMax = (MAX_WIDTH < RegWMax) ? MAX_WIDTH : RegWMax;
   localparam int unsigned EffRMax = (MAX_ROWS < RegRMax) ? MAX_ROWS : RegRMax;
   localparam int unsigned IdxW    = $clog2(4 * EffWMax);
   localparam logic [15:0] MaxW16  = 16'(EffWMax);
   localparam logic [15:0] MaxR16  = 16'(EffRMax);

   typedef enum logic [2:0] {
      PH_HEAD, PH_COUNT, PH_RUNVAL, PH_LIT, PH_FLAT, PH_DONE
   } phase_type;

   phase_type        phase_ff, phase_in;
   logic [7:0]       head_ff [3];
   logic [7:0]       head_in [3];
   logic [1:0]       ch_ff, ch_in;
   logic [12:0]      col_ff, col_in;
   logic [7:0]       pend_ff, pend_in;
   logic [11:0]      row_ff, row_in;
   logic [IdxW-1:0]  idx_ff, idx_in;
   logic             err_ff, err_in;

   logic [15:0] w_raw, w_clamp, r_raw, r_clamp;
   logic [12:0] w;
   logic [11:0] r;
   logic [12:0] rem;
   logic [11:0] row_inc;
   logic        last_row;
   logic [15:0] idx_next16;
   logic [15:0] four_w16;
   logic [14:0] scan_w;
   logic        new_style;
   logic        finish;
   logic        adv;
   logic        fail;
   logic [2:0]  fail_st;
   logic [12:0] col_new;
   logic [7:0]  pend_new;

   // Clamp the configured width and row count
   always_comb begin
      w_raw   = 16'(row_width);
      w_clamp = (w_raw == 16'd0) ? 16'd1 : w_raw;
      w_clamp = (w_clamp > MaxW16) ? MaxW16 : w_clamp;
      w       = w_clamp[12:0];
      r_raw   = 16'(image_rows);
      r_clamp = (r_raw == 16'd0) ? 16'd1 : r_raw;
      r_clamp = (r_clamp > MaxR16) ? MaxR16 : r_clamp;
      r       = r_clamp[11:0];
   end

   assign rem        = (col_ff < w) ? (w - col_ff) : 13'd0;
   assign row_inc    = row_ff + 12'd1;
   assign last_row   = (row_inc >= r);
   assign idx_next16 = 16'(idx_ff) + 16'd1;
   assign four_w16   = {1'b0, w, 2'b00};
   assign scan_w     = {head_ff[2][6:0], data_byte};
   assign new_style  = (head_ff[0] == rgbe_pkg::NEW_STYLE_MARK) &&
                       (head_ff[1] == rgbe_pkg::NEW_STYLE_MARK) &&
                       (head_ff[2] < rgbe_pkg::RUN_BIAS);

   // Decode one byte against the current state
   always_comb begin
      phase_in = phase_ff;
      head_in  = head_ff;
      ch_in    = ch_ff;
      col_in   = col_ff;
      pend_in  = pend_ff;
      row_in   = row_ff;
      idx_in   = idx_ff;
      err_in   = err_ff;
      finish   = 1'b0;
      adv      = 1'b0;
      fail     = 1'b0;
      fail_st  = rgbe_pkg::ST_OK;
      col_new  = col_ff;
      pend_new = pend_ff;
      push     = 1'b0;

      bundle.multi      = 1'b0;
      bundle.status     = rgbe_pkg::ST_OK;
      bundle.channel    = ch_ff;
      bundle.row        = row_ff[10:0];
      bundle.start_x    = col_ff[11:0];
      bundle.len        = 7'd0;
      bundle.value      = data_byte;
      bundle.is_run     = 1'b0;
      bundle.row_done   = 1'b0;
      bundle.image_done = 1'b0;
      bundle.head0      = head_ff[0];
      bundle.head1      = head_ff[1];
      bundle.head2      = head_ff[2];

      if (accept && !err_ff) begin
         unique case (phase_ff)
            PH_HEAD: begin
               if (idx_ff < IdxW'(3)) begin
                  // collect head bytes
                  head_in[idx_ff[1:0]] = data_byte;
                  idx_in = idx_ff + IdxW'(1);
               end else if (new_style) begin
                  if (scan_w != {2'b00, w}) begin
                     fail    = 1'b1;
                     fail_st = rgbe_pkg::ST_WIDTH_MISMATCH;
                  end else begin
                     phase_in = PH_COUNT;
                     ch_in    = 2'd0;
                     col_in   = 13'd0;
                     pend_in  = 8'd0;
                     idx_in   = '0;
                  end
               end else begin
                  // flat head: four single-pixel spans at column 0
                  push           = 1'b1;
                  bundle.multi   = 1'b1;
                  bundle.channel = rgbe_pkg::CH_EXP;
                  bundle.start_x = 12'd0;
                  bundle.len     = 7'd1;
                  phase_in       = PH_FLAT;
                  idx_in         = IdxW'(4);
                  if (w == 13'd1) begin
                     finish = 1'b1;
                  end
               end
            end
            PH_FLAT: begin
               push           = 1'b1;
               bundle.channel = idx_ff[1:0];
               bundle.start_x = 12'(idx_ff >> 2);
               bundle.len     = 7'd1;
               idx_in         = idx_ff + IdxW'(1);
               if (idx_next16 >= four_w16) begin
                  finish = 1'b1;
               end
            end
            PH_COUNT: begin
               if (data_byte > rgbe_pkg::RUN_BIAS) begin
                  pend_in  = data_byte - rgbe_pkg::RUN_BIAS;
                  phase_in = PH_RUNVAL;
               end else if (data_byte == 8'd0) begin
                  fail    = 1'b1;
                  fail_st = rgbe_pkg::ST_ZERO_LITERAL;
               end else if (13'(data_byte) > rem) begin
                  fail    = 1'b1;
                  fail_st = rgbe_pkg::ST_LITERAL_OVERFLOW;
               end else begin
                  pend_in  = data_byte;
                  phase_in = PH_LIT;
               end
            end
            PH_RUNVAL: begin
               if (13'(pend_ff) > rem) begin
                  fail    = 1'b1;
                  fail_st = rgbe_pkg::ST_RUN_OVERFLOW;
               end else begin
                  adv           = 1'b1;
                  col_new       = col_ff + 13'(pend_ff);
                  pend_new      = 8'd0;
                  bundle.len    = pend_ff[6:0];
                  bundle.is_run = 1'b1;
               end
            end
            PH_LIT: begin
               adv        = 1'b1;
               col_new    = col_ff + 13'd1;
               pend_new   = (pend_ff != 8'd0) ? (pend_ff - 8'd1) : 8'd0;
               bundle.len = 7'd1;
            end
            PH_DONE: begin
            end
            default: begin
            end
         endcase
      end

      // Advance after a run or literal span
      if (adv) begin
         push    = 1'b1;
         col_in  = col_new;
         pend_in = pend_new;
         if (col_new >= w) begin
            if (ch_ff == rgbe_pkg::CH_EXP) begin
               finish = 1'b1;
            end else begin
               ch_in    = ch_ff + 2'd1;
               col_in   = 13'd0;
               phase_in = PH_COUNT;
            end
         end else if (phase_ff != PH_LIT || pend_new == 8'd0) begin
            phase_in = PH_COUNT;
         end
      end

      // Close the row
      if (finish) begin
         bundle.row_done   = 1'b1;
         bundle.image_done = last_row;
         row_in   = row_inc;
         ch_in    = 2'd0;
         col_in   = 13'd0;
         pend_in  = 8'd0;
         idx_in   = '0;
         phase_in = last_row ? PH_DONE : PH_HEAD;
      end

      // Report an error and latch it
      if (fail) begin
         push          = 1'b1;
         err_in        = 1'b1;
         bundle.status = fail_st;
         bundle.len    = 7'd0;
         if (fail_st == rgbe_pkg::ST_WIDTH_MISMATCH) begin
            bundle.channel = 2'd0;
            bundle.start_x = 12'd0;
         end
      end
   end

   // Hold decode state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEAD;
         head_ff  <= '{default: 8'd0};
         ch_ff    <= 2'd0;
         col_ff   <= 13'd0;
         pend_ff  <= 8'd0;
         row_ff   <= 12'd0;
         idx_ff   <= '0;
         err_ff   <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         head_ff  <= head_in;
         ch_ff    <= ch_in;
         col_ff   <= col_in;
         pend_ff  <= pend_in;
         row_ff   <= row_in;
         idx_ff   <= idx_in;
         err_ff   <= err_in;
      end
   end

endmodule
